// ----- design/mcst_pkg.sv -----
// Shared types and constants for the multi-channel tick timer.
// Used by the channel interfaces, the remainder unit and the top level.
package mcst_pkg;

    localparam int DATA_W      = 32;
    localparam int FUNC_W      = 2;
    localparam int CHAN_W      = 3;
    localparam int MAX_RESULTS = 8;
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);
    localparam int REM_CNT_W   = $clog2(DATA_W);

    localparam logic ST_OK  = 1'b0;
    localparam logic ST_ERR = 1'b1;

    typedef enum logic [FUNC_W-1:0] {
        F_REGISTER = 2'd0,
        F_START    = 2'd1,
        F_STOP     = 2'd2,
        F_TICK     = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EMIT,
        S_SCAN,
        S_CALC,
        S_DIV,
        S_FIRE,
        S_FLUSH
    } t_state;

    // Result of the serial remainder unit.
    typedef struct packed {
        logic done;
        logic zero;
    } t_rem_res;

endpackage

// ----- design/mcst_if.sv -----
// Valid/ready channel interfaces for timer commands and timer results.
// Depends on mcst_pkg for the field widths.
interface mcst_cmd_if;
    logic                         valid;
    logic                         ready;
    logic [mcst_pkg::FUNC_W-1:0]  func;
    logic [mcst_pkg::CHAN_W-1:0]  channel;
    logic [mcst_pkg::DATA_W-1:0]  period_ticks;
    logic                         one_shot;

    modport source (output valid, func, channel, period_ticks, one_shot, input ready);
    modport sink   (input valid, func, channel, period_ticks, one_shot, output ready);
endinterface

interface mcst_res_if;
    logic                         valid;
    logic                         ready;
    logic                         status;
    logic [mcst_pkg::CHAN_W-1:0]  slot;
    logic                         fired;
    logic                         last;

    modport source (output valid, status, slot, fired, last, input ready);
    modport sink   (input valid, status, slot, fired, last, output ready);
endinterface

// ----- design/mcst_rem.sv -----
// Bit-serial restoring remainder unit, one dividend bit per cycle.
// Depends on mcst_pkg; shared by all period checks of a tick scan.
module mcst_rem (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [mcst_pkg::DATA_W-1:0] i_dividend,
    input  logic [mcst_pkg::DATA_W-1:0] i_divisor,
    output mcst_pkg::t_rem_res          o_res
);

    logic                           r_busy, n_busy;
    logic                           r_done, n_done;
    logic [mcst_pkg::REM_CNT_W-1:0] r_cnt, n_cnt;
    logic [mcst_pkg::DATA_W-1:0]    r_rem, n_rem;
    logic [mcst_pkg::DATA_W-1:0]    r_dvd, n_dvd;
    logic [mcst_pkg::DATA_W-1:0]    r_dvs, n_dvs;
    logic [mcst_pkg::DATA_W:0]      shifted;
    logic [mcst_pkg::DATA_W:0]      diff;

    always_comb begin
        shifted = {r_rem, r_dvd[mcst_pkg::DATA_W-1]};
        diff    = shifted - {1'b0, r_dvs};
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_dvd   = r_dvd;
        n_dvs   = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_dvd  = i_dividend;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            // The partial remainder stays below the divisor, so it fits in DATA_W bits.
            n_rem = diff[mcst_pkg::DATA_W] ? shifted[mcst_pkg::DATA_W-1:0]
                                           : diff[mcst_pkg::DATA_W-1:0];
            n_dvd = {r_dvd[mcst_pkg::DATA_W-2:0], 1'b0};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == mcst_pkg::REM_CNT_W'(mcst_pkg::DATA_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_dvd <= n_dvd;
        r_dvs <= n_dvs;
    end

    assign o_res.done = r_done;
    assign o_res.zero = (r_rem == '0);

endmodule

// ----- design/multi_channel_software_timer.sv -----
// Multi-channel periodic and one-shot tick timer. Register, start and stop commands each return
// one word. On a tick each running channel's elapsed count, if nonzero, is tested against its
// period by one shared bit-serial remainder unit (32 steps). The block takes no command while
// a tick scan or a result is in progress.
// Depends on mcst_pkg, mcst_if and mcst_rem.
module multi_channel_software_timer #(
    parameter int CHANNELS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    mcst_cmd_if.sink          i_cmd,
    mcst_res_if.source        o_res
);

    localparam int IW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int UCW = $clog2(CHANNELS + 1);

    mcst_pkg::t_state                 r_state, n_state;
    logic [IW-1:0]                    r_idx, n_idx;
    logic [mcst_pkg::DATA_W-1:0]      r_tick, n_tick;
    logic [UCW-1:0]                   r_used_cnt, n_used_cnt;
    logic [CHANNELS-1:0]              r_used, n_used;
    logic [CHANNELS-1:0]              r_run, n_run;
    logic [CHANNELS-1:0]              r_shot, n_shot;
    logic                             r_pend_v, n_pend_v;
    logic [mcst_pkg::CHAN_W-1:0]      r_pend_slot, n_pend_slot;
    logic [mcst_pkg::RES_CNT_W-1:0]   r_n, n_n;
    logic                             r_cmd_status, n_cmd_status;
    logic [mcst_pkg::CHAN_W-1:0]      r_cmd_slot, n_cmd_slot;
    logic                             r_out_v, n_out_v;
    logic                             r_out_status, n_out_status;
    logic [mcst_pkg::CHAN_W-1:0]      r_out_slot, n_out_slot;
    logic                             r_out_fired, n_out_fired;
    logic                             r_out_last, n_out_last;

    logic [mcst_pkg::DATA_W-1:0]      r_period_mem [CHANNELS];
    logic [mcst_pkg::DATA_W-1:0]      r_mark_mem [CHANNELS];
    logic [mcst_pkg::DATA_W-1:0]      r_per_q;
    logic [mcst_pkg::DATA_W-1:0]      r_mark_q;

    logic                             accept;
    logic                             out_free;
    logic                             last_idx;
    logic [IW-1:0]                    free_idx;
    logic [IW+mcst_pkg::CHAN_W-1:0]   free_wide;
    logic [IW+mcst_pkg::CHAN_W-1:0]   idx_wide;
    logic [IW+mcst_pkg::CHAN_W-1:0]   ch_wide;
    logic [IW-1:0]                    ch_idx;
    logic [mcst_pkg::CHAN_W-1:0]      idx_slot;
    logic                             ch_bad;
    logic [mcst_pkg::DATA_W-1:0]      elapsed;
    logic                             per_we;
    logic                             mark_we;
    logic [IW-1:0]                    waddr;
    logic                             rem_start;
    mcst_pkg::t_rem_res               rem_res;

    // Lowest free slot.
    always_comb begin
        free_idx = '0;
        for (int i = CHANNELS - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                free_idx = IW'(i);
            end
        end
    end

    assign free_wide = {mcst_pkg::CHAN_W'(0), free_idx};
    assign idx_wide  = {mcst_pkg::CHAN_W'(0), r_idx};
    assign idx_slot  = idx_wide[mcst_pkg::CHAN_W-1:0];
    assign ch_wide   = {IW'(0), i_cmd.channel};
    assign ch_idx    = ch_wide[IW-1:0];
    assign ch_bad    = (32'(i_cmd.channel) >= 32'(CHANNELS));
    assign last_idx  = (r_idx == IW'(CHANNELS - 1));
    assign elapsed   = r_tick - r_mark_q;
    assign accept    = i_cmd.valid && i_cmd.ready;
    assign out_free  = !r_out_v || o_res.ready;

    assign i_cmd.ready  = (r_state == mcst_pkg::S_IDLE);
    assign o_res.valid  = r_out_v;
    assign o_res.status = r_out_status;
    assign o_res.slot   = r_out_slot;
    assign o_res.fired  = r_out_fired;
    assign o_res.last   = r_out_last;

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_tick       = r_tick;
        n_used_cnt   = r_used_cnt;
        n_used       = r_used;
        n_run        = r_run;
        n_shot       = r_shot;
        n_pend_v     = r_pend_v;
        n_pend_slot  = r_pend_slot;
        n_n          = r_n;
        n_cmd_status = r_cmd_status;
        n_cmd_slot   = r_cmd_slot;
        n_out_v      = r_out_v && !o_res.ready;
        n_out_status = r_out_status;
        n_out_slot   = r_out_slot;
        n_out_fired  = r_out_fired;
        n_out_last   = r_out_last;
        per_we       = 1'b0;
        mark_we      = 1'b0;
        waddr        = free_idx;
        rem_start    = 1'b0;

        unique case (r_state)
            mcst_pkg::S_IDLE: begin
                if (accept) begin
                    unique case (mcst_pkg::t_func'(i_cmd.func))
                        mcst_pkg::F_REGISTER: begin
                            n_state = mcst_pkg::S_EMIT;
                            if (i_cmd.period_ticks == '0 || r_used_cnt >= UCW'(CHANNELS)) begin
                                n_cmd_status = mcst_pkg::ST_ERR;
                                n_cmd_slot   = '0;
                            end else begin
                                per_we             = 1'b1;
                                mark_we            = 1'b1;
                                n_used[free_idx]   = 1'b1;
                                n_run[free_idx]    = 1'b0;
                                n_shot[free_idx]   = i_cmd.one_shot;
                                n_used_cnt         = r_used_cnt + 1'b1;
                                n_cmd_status       = mcst_pkg::ST_OK;
                                n_cmd_slot         = free_wide[mcst_pkg::CHAN_W-1:0];
                            end
                        end
                        mcst_pkg::F_START, mcst_pkg::F_STOP: begin
                            n_state    = mcst_pkg::S_EMIT;
                            n_cmd_slot = i_cmd.channel;
                            waddr      = ch_idx;
                            if (ch_bad) begin
                                n_cmd_status = mcst_pkg::ST_ERR;
                            end else begin
                                n_cmd_status = mcst_pkg::ST_OK;
                                if (mcst_pkg::t_func'(i_cmd.func) == mcst_pkg::F_START) begin
                                    mark_we       = 1'b1;
                                    n_run[ch_idx] = 1'b1;
                                end else if (r_used[ch_idx]) begin
                                    n_used[ch_idx] = 1'b0;
                                    n_run[ch_idx]  = 1'b0;
                                    n_used_cnt     = r_used_cnt - 1'b1;
                                end
                            end
                        end
                        mcst_pkg::F_TICK: begin
                            // The count only advances while some slot is in use.
                            if (r_used_cnt != '0) begin
                                n_tick   = r_tick + 1'b1;
                                n_idx    = '0;
                                n_pend_v = 1'b0;
                                n_n      = '0;
                                n_state  = mcst_pkg::S_SCAN;
                            end
                        end
                    endcase
                end
            end
            mcst_pkg::S_EMIT: begin
                if (out_free) begin
                    n_out_v      = 1'b1;
                    n_out_status = r_cmd_status;
                    n_out_slot   = r_cmd_slot;
                    n_out_fired  = 1'b0;
                    n_out_last   = 1'b1;
                    n_state      = mcst_pkg::S_IDLE;
                end
            end
            mcst_pkg::S_SCAN: begin
                // Period and mark of r_idx are read this cycle and arrive in S_CALC.
                if (r_run[r_idx] && r_used[r_idx]) begin
                    n_state = mcst_pkg::S_CALC;
                end else begin
                    n_state = last_idx ? mcst_pkg::S_FLUSH : mcst_pkg::S_SCAN;
                    n_idx   = last_idx ? r_idx : r_idx + 1'b1;
                end
            end
            mcst_pkg::S_CALC: begin
                if (elapsed == '0) begin
                    n_state = last_idx ? mcst_pkg::S_FLUSH : mcst_pkg::S_SCAN;
                    n_idx   = last_idx ? r_idx : r_idx + 1'b1;
                end else begin
                    rem_start = 1'b1;
                    n_state   = mcst_pkg::S_DIV;
                end
            end
            mcst_pkg::S_DIV: begin
                if (rem_res.done) begin
                    if (rem_res.zero && r_n < mcst_pkg::RES_CNT_W'(mcst_pkg::MAX_RESULTS)) begin
                        n_state = mcst_pkg::S_FIRE;
                    end else begin
                        n_state = last_idx ? mcst_pkg::S_FLUSH : mcst_pkg::S_SCAN;
                        n_idx   = last_idx ? r_idx : r_idx + 1'b1;
                    end
                    if (rem_res.zero && r_shot[r_idx]) begin
                        n_used[r_idx] = 1'b0;
                        n_run[r_idx]  = 1'b0;
                        if (r_used_cnt != '0) begin
                            n_used_cnt = r_used_cnt - 1'b1;
                        end
                    end
                end
            end
            mcst_pkg::S_FIRE: begin
                // The previous firing is held back until it is known not to be the last word.
                if (!r_pend_v || out_free) begin
                    if (r_pend_v) begin
                        n_out_v      = 1'b1;
                        n_out_status = mcst_pkg::ST_OK;
                        n_out_slot   = r_pend_slot;
                        n_out_fired  = 1'b1;
                        n_out_last   = 1'b0;
                    end
                    n_pend_v    = 1'b1;
                    n_pend_slot = idx_slot;
                    n_n         = r_n + 1'b1;
                    n_state     = last_idx ? mcst_pkg::S_FLUSH : mcst_pkg::S_SCAN;
                    n_idx       = last_idx ? r_idx : r_idx + 1'b1;
                end
            end
            mcst_pkg::S_FLUSH: begin
                if (!r_pend_v) begin
                    n_state = mcst_pkg::S_IDLE;
                end else if (out_free) begin
                    n_out_v      = 1'b1;
                    n_out_status = mcst_pkg::ST_OK;
                    n_out_slot   = r_pend_slot;
                    n_out_fired  = 1'b1;
                    n_out_last   = 1'b1;
                    n_pend_v     = 1'b0;
                    n_state      = mcst_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mcst_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= mcst_pkg::S_IDLE;
            r_tick     <= '0;
            r_used_cnt <= '0;
            r_used     <= '0;
            r_run      <= '0;
            r_shot     <= '0;
            r_pend_v   <= 1'b0;
            r_n        <= '0;
            r_out_v    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_tick     <= n_tick;
            r_used_cnt <= n_used_cnt;
            r_used     <= n_used;
            r_run      <= n_run;
            r_shot     <= n_shot;
            r_pend_v   <= n_pend_v;
            r_n        <= n_n;
            r_out_v    <= n_out_v;
        end
        r_idx        <= n_idx;
        r_pend_slot  <= n_pend_slot;
        r_cmd_status <= n_cmd_status;
        r_cmd_slot   <= n_cmd_slot;
        r_out_status <= n_out_status;
        r_out_slot   <= n_out_slot;
        r_out_fired  <= n_out_fired;
        r_out_last   <= n_out_last;
    end

    // Period and start mark tables; read each cycle, used only for a slot in use.
    always_ff @(posedge i_clk) begin
        if (per_we) begin
            r_period_mem[waddr] <= i_cmd.period_ticks;
        end
        if (mark_we) begin
            r_mark_mem[waddr] <= r_tick;
        end
        r_per_q  <= r_period_mem[r_idx];
        r_mark_q <= r_mark_mem[r_idx];
    end

    mcst_rem u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (rem_start),
        .i_dividend (elapsed),
        .i_divisor  (r_per_q),
        .o_res      (rem_res)
    );

`ifndef SYNTH
    a_used_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_used_cnt) == $countones(r_used))
        else $error("used count disagrees with the slots in use");

    a_idle_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mcst_pkg::S_IDLE) |-> !r_pend_v)
        else $error("firing word left behind after a tick scan");

    a_result_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= mcst_pkg::RES_CNT_W'(mcst_pkg::MAX_RESULTS))
        else $error("too many firing words reported for one tick");

    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rem_start |-> (r_per_q != '0))
        else $error("remainder started with a zero period");
`endif

endmodule
